/* src/bsst_pkg.sv */
// Shared types and constants for the buffer slot state tracker.
package bsst_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int STATE_W   = 4;
    localparam int USE_W     = 5;
    localparam int LIMIT_W   = 5;
    localparam int OUT_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 5;

    localparam logic [USE_W-1:0]   USE_RST  = 5'd13;
    localparam logic [STATE_W-1:0] IDLE_RST = 4'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_CODE    = 1'b1;

    localparam logic FUNC_ACQUIRE = 1'b0;
    localparam logic FUNC_SET     = 1'b1;

    typedef struct packed {
        logic               func;
        logic [STATE_W-1:0] match_state;
        logic [STATE_W-1:0] target_state;
        logic [3:0]         slot_index;
        logic [LIMIT_W-1:0] limit_count;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [OUT_W-1:0] slot_out;
    } t_rsp;

endpackage

/* src/buffer_slot_state_tracker_unit.sv */
// Top level: slot state table with a sequenced scan over a single RAM read port.
// A set naming a slot outside the active range, or any word when no slots are active, is answered in
// the cycle after it is accepted, without a scan; otherwise a scan reads each active slot in turn
// (n = active slot count), waits out the RAM read latency and closes; an acquire hit at slot k ends it early.
// A new word is accepted only while not busy, so not during a scan; one per cycle if rejected.
// Reset (synchronous, active low): slots read as idle code 0, slots_in_use 13; receiver cannot stall.
module buffer_slot_state_tracker_unit #(
    parameter int SLOTS = bsst_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  bsst_pkg::t_req                 i_req,
    output logic                           o_strobe,
    output bsst_pkg::t_rsp                 o_rsp,
    input  logic                           i_cfg_we,
    input  logic [bsst_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bsst_pkg::CFG_W-1:0]     i_cfg_wdata
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CW    = (CNT_W > bsst_pkg::USE_W) ? CNT_W : bsst_pkg::USE_W;
    localparam int SW    = bsst_pkg::STATE_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                         r_state, n_state;
    logic [bsst_pkg::USE_W-1:0]   r_use;
    logic [SW-1:0]                r_idle;
    logic [SLOTS-1:0]             r_valid;
    logic                         r_rvalid;

    logic                         r_func;
    logic [SW-1:0]                r_match, r_target;
    logic [3:0]                   r_named;
    logic [bsst_pkg::LIMIT_W-1:0] r_limit;
    logic [CW-1:0]                r_n;

    logic [CW-1:0]                r_addr, n_addr;
    logic [CW-1:0]                r_paddr, n_paddr;
    logic                         r_pend, n_pend;
    logic [CW-1:0]                r_cnt, n_cnt;

    logic                         r_strobe, n_strobe;
    bsst_pkg::t_rsp               r_rsp, n_rsp;

    logic                         we;
    logic [IDX_W-1:0]             waddr;
    logic [SW-1:0]                wdata;
    logic [IDX_W-1:0]             raddr;
    logic [SW-1:0]                rdata, cur;
    logic [CW-1:0]                n_act, named_w, limit_w, cnt_inc;
    logic                         accept;

    bsst_ram #(
        .WIDTH(SW),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign accept  = i_start && (r_state == S_IDLE);
    assign raddr   = r_addr[IDX_W-1:0];
    assign cur     = r_rvalid ? rdata : bsst_pkg::IDLE_RST;
    assign n_act   = (CW'(r_use) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(r_use);
    assign named_w = CW'(r_named);
    assign limit_w = CW'(r_limit);
    assign cnt_inc = r_cnt + CW'(1);

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_paddr  = r_paddr;
        n_pend   = 1'b0;
        n_cnt    = r_cnt;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        we       = 1'b0;
        waddr    = r_paddr[IDX_W-1:0];
        wdata    = r_target;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr = '0;
                    n_cnt  = '0;
                    if (n_act == '0 || (i_req.func == bsst_pkg::FUNC_SET
                            && CW'(i_req.slot_index) >= n_act)) begin
                        n_strobe = 1'b1;
                        n_rsp    = '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_addr < r_n) begin
                    n_pend  = 1'b1;
                    n_paddr = r_addr;
                    n_addr  = r_addr + CW'(1);
                end
                if (r_pend) begin
                    if (r_func == bsst_pkg::FUNC_ACQUIRE) begin
                        if (cur == r_match) begin
                            we             = 1'b1;
                            n_state        = S_IDLE;
                            n_pend         = 1'b0;
                            n_strobe       = 1'b1;
                            n_rsp.found    = 1'b1;
                            n_rsp.slot_out = bsst_pkg::OUT_W'(r_paddr);
                        end
                    end else if (cur == r_target) begin
                        n_cnt = cnt_inc;
                        if (r_limit != '0 && cnt_inc >= limit_w) begin
                            we    = 1'b1;
                            wdata = r_idle;
                        end
                    end
                end else if (r_addr >= r_n) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    if (r_func == bsst_pkg::FUNC_SET) begin
                        we             = 1'b1;
                        waddr          = named_w[IDX_W-1:0];
                        n_rsp.found    = 1'b1;
                        n_rsp.slot_out = r_named;
                    end else begin
                        n_rsp = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_use    <= bsst_pkg::USE_RST;
            r_idle   <= bsst_pkg::IDLE_RST;
            r_valid  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bsst_pkg::CFG_SLOTS_IN_USE: r_use  <= i_cfg_wdata[bsst_pkg::USE_W-1:0];
                    bsst_pkg::CFG_IDLE_CODE:    r_idle <= i_cfg_wdata[SW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rvalid <= r_valid[raddr];
        r_addr   <= n_addr;
        r_paddr  <= n_paddr;
        r_cnt    <= n_cnt;
        r_rsp    <= n_rsp;
        if (accept) begin
            r_func   <= i_req.func;
            r_match  <= i_req.match_state;
            r_target <= i_req.target_state;
            r_named  <= i_req.slot_index;
            r_limit  <= i_req.limit_count;
            r_n      <= n_act;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

/* src/bsst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bsst_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bsst_checker.sv */
// Port-level checker for the slot state tracker, bound to the top level.
module bsst_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           o_busy,
    input logic           o_strobe,
    input bsst_pkg::t_rsp o_rsp
);

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_strobe))
        else $error("accepted word made no progress");

    a_strobe_not_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> !o_strobe)
        else $error("result shown as a scan starts");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !o_busy)
        else $error("result shown while busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_rsp.found) |-> (o_rsp.slot_out == '0))
        else $error("miss with nonzero slot");

    a_busy_ends_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_strobe)
        else $error("busy dropped without a result");

endmodule

bind buffer_slot_state_tracker_unit bsst_checker u_bsst_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_strobe(o_strobe),
    .o_rsp   (o_rsp)
);

/* verif/tb.sv */
// Testbench for the buffer slot state tracker: directed table, then random phases vs a predictor.
`timescale 1ns / 100ps

module tb;

    localparam int CYC_LIMIT = 400000;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                      kind;
        logic [bsst_pkg::CFG_IDX_W-1:0] ridx;
        logic [bsst_pkg::CFG_W-1:0]     rval;
        bsst_pkg::t_req                 rq;
        bit                             lit;
        bsst_pkg::t_rsp                 want;
    } t_stim_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_start;
    logic                           o_busy;
    bsst_pkg::t_req                 i_req;
    logic                           o_strobe;
    bsst_pkg::t_rsp                 o_rsp;
    logic                           i_cfg_we;
    logic [bsst_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bsst_pkg::CFG_W-1:0]     i_cfg_wdata;

    logic [bsst_pkg::STATE_W-1:0] slot_tbl [bsst_pkg::SLOTS_DEF];
    logic [bsst_pkg::USE_W-1:0]   use_cfg;
    logic [bsst_pkg::STATE_W-1:0] idle_cfg;

    bsst_pkg::t_rsp rsp_pending [$];
    t_stim_row      stim_tbl [$];
    int             errs = 0;
    int             cyc = 0;
    bit             idle_on;

    buffer_slot_state_tracker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int active_slots();
        return (use_cfg > bsst_pkg::SLOTS_DEF) ? bsst_pkg::SLOTS_DEF : int'(use_cfg);
    endfunction

    // applies one operation to the shadow table and returns its response
    function automatic bsst_pkg::t_rsp predict_slot_op(input bsst_pkg::t_req rq);
        int             n;
        int             cnt;
        bsst_pkg::t_rsp r;
        n = active_slots();
        r = '0;
        if (rq.func == bsst_pkg::FUNC_ACQUIRE) begin
            for (int i = 0; i < n; i++) begin
                if (!r.found && slot_tbl[i] == rq.match_state) begin
                    r.found    = 1'b1;
                    r.slot_out = i[bsst_pkg::OUT_W-1:0];
                    slot_tbl[i] = rq.target_state;
                end
            end
        end else if (int'(rq.slot_index) < n) begin
            cnt        = 0;
            r.found    = 1'b1;
            r.slot_out = rq.slot_index;
            for (int i = 0; i < n; i++) begin
                if (slot_tbl[i] == rq.target_state) begin
                    cnt++;
                    if (rq.limit_count != 0 && cnt >= int'(rq.limit_count)) begin
                        slot_tbl[i] = idle_cfg;
                    end
                end
            end
            slot_tbl[rq.slot_index] = rq.target_state;
        end
        return r;
    endfunction

    function automatic logic [bsst_pkg::STATE_W-1:0] pick_code();
        if ($urandom_range(99) < 75) begin
            return bsst_pkg::STATE_W'($urandom_range(3));
        end
        return bsst_pkg::STATE_W'($urandom_range(15));
    endfunction

    // mostly well-formed: hits on live states, names inside the active range
    function automatic bsst_pkg::t_req gen_slot_op();
        bsst_pkg::t_req rq;
        int             n;
        int             roll;
        n = active_slots();
        rq.func         = logic'($urandom_range(1));
        rq.target_state = pick_code();
        if (n > 0 && $urandom_range(99) < 60) begin
            rq.match_state = slot_tbl[$urandom_range(n - 1)];
        end else begin
            rq.match_state = pick_code();
        end
        if (n > 0 && $urandom_range(99) < 85) begin
            rq.slot_index = 4'($urandom_range(n - 1));
        end else begin
            rq.slot_index = 4'($urandom_range(15));
        end
        roll = $urandom_range(99);
        if (roll < 50) begin
            rq.limit_count = bsst_pkg::LIMIT_W'($urandom_range(3, 1));
        end else if (roll < 70) begin
            rq.limit_count = '0;
        end else if (roll < 90) begin
            rq.limit_count = bsst_pkg::LIMIT_W'($urandom_range(16, 4));
        end else begin
            rq.limit_count = bsst_pkg::LIMIT_W'($urandom_range(31, 17));
        end
        return rq;
    endfunction

    function automatic void add_item(input logic fn, input int ms, input int ts, input int si,
                                     input int lc, input bit lit, input int wf, input int wo);
        t_stim_row row;
        row.kind               = ROW_ITEM;
        row.ridx               = '0;
        row.rval               = '0;
        row.rq.func            = fn;
        row.rq.match_state     = bsst_pkg::STATE_W'(ms);
        row.rq.target_state    = bsst_pkg::STATE_W'(ts);
        row.rq.slot_index      = 4'(si);
        row.rq.limit_count     = bsst_pkg::LIMIT_W'(lc);
        row.lit                = lit;
        row.want.found         = wf[0];
        row.want.slot_out      = bsst_pkg::OUT_W'(wo);
        stim_tbl.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [bsst_pkg::CFG_IDX_W-1:0] idx, input int val);
        t_stim_row row;
        row.kind = ROW_CFG;
        row.ridx = idx;
        row.rval = bsst_pkg::CFG_W'(val);
        row.rq   = '0;
        row.lit  = 1'b0;
        row.want = '0;
        stim_tbl.push_back(row);
    endfunction

    // entered and left just after a falling edge
    task automatic drive_word(input bsst_pkg::t_req rq, input bit lit,
                              input bsst_pkg::t_rsp want);
        bsst_pkg::t_rsp p;
        if (idle_on && $urandom_range(99) < 28) begin
            i_start <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < 28);
        end
        i_req   <= rq;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        p = predict_slot_op(rq);
        rsp_pending.push_back(lit ? want : p);
        @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [bsst_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bsst_pkg::CFG_W-1:0] val);
        i_start <= 1'b0;
        do @(negedge i_clk); while (rsp_pending.size() != 0 || o_busy);
        repeat (2) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == bsst_pkg::CFG_SLOTS_IN_USE) begin
            use_cfg = val;
        end else begin
            idle_cfg = val[bsst_pkg::STATE_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        bsst_pkg::t_rsp exp_rsp;
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $realtime, rsp_pending.size());
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n && o_strobe) begin
            if (rsp_pending.size() == 0) begin
                $display("%0t: unexpected word found=%0d slot=%0d", $realtime,
                         o_rsp.found, o_rsp.slot_out);
                errs <= errs + 1;
            end else begin
                exp_rsp = rsp_pending.pop_front();
                if (o_rsp.found !== exp_rsp.found || o_rsp.slot_out !== exp_rsp.slot_out) begin
                    $display("%0t: mismatch exp found=%0d slot=%0d got found=%0d slot=%0d",
                             $realtime, exp_rsp.found, exp_rsp.slot_out,
                             o_rsp.found, o_rsp.slot_out);
                    errs <= errs + 1;
                end
            end
        end
    end

    initial begin
        bsst_pkg::t_req rq;
        bsst_pkg::t_rsp nil;
        int             u;
        int             nitems;

        idle_on     = 1'b1;
        nil         = '0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        use_cfg     = bsst_pkg::USE_RST;
        idle_cfg    = bsst_pkg::IDLE_RST;
        for (int i = 0; i < bsst_pkg::SLOTS_DEF; i++) begin
            slot_tbl[i] = bsst_pkg::IDLE_RST;
        end

        add_item(bsst_pkg::FUNC_ACQUIRE, 0, 5, 0, 0, 1, 1, 0);
        add_item(bsst_pkg::FUNC_ACQUIRE, 0, 5, 0, 0, 1, 1, 1);
        add_item(bsst_pkg::FUNC_ACQUIRE, 15, 1, 0, 0, 1, 0, 0);
        add_item(bsst_pkg::FUNC_SET, 0, 3, 15, 0, 1, 0, 0);
        add_item(bsst_pkg::FUNC_SET, 0, 5, 13, 1, 1, 0, 0);
        add_item(bsst_pkg::FUNC_SET, 0, 15, 12, 0, 1, 1, 12);
        add_item(bsst_pkg::FUNC_SET, 0, 5, 2, 1, 0, 0, 0);
        add_item(bsst_pkg::FUNC_SET, 0, 5, 3, 16, 0, 0, 0);
        add_item(bsst_pkg::FUNC_SET, 15, 5, 4, 31, 0, 0, 0);
        add_item(bsst_pkg::FUNC_SET, 0, 5, 5, 2, 0, 0, 0);
        add_item(bsst_pkg::FUNC_ACQUIRE, 5, 10, 0, 0, 0, 0, 0);
        add_cfg(bsst_pkg::CFG_IDLE_CODE, 15);
        add_item(bsst_pkg::FUNC_SET, 0, 5, 6, 1, 0, 0, 0);
        add_item(bsst_pkg::FUNC_ACQUIRE, 15, 0, 0, 0, 0, 0, 0);
        add_cfg(bsst_pkg::CFG_SLOTS_IN_USE, 0);
        add_item(bsst_pkg::FUNC_ACQUIRE, 0, 1, 0, 0, 1, 0, 0);
        add_item(bsst_pkg::FUNC_SET, 0, 1, 0, 1, 1, 0, 0);
        add_cfg(bsst_pkg::CFG_SLOTS_IN_USE, 31);
        add_item(bsst_pkg::FUNC_SET, 0, 9, 15, 0, 1, 1, 15);
        add_item(bsst_pkg::FUNC_ACQUIRE, 9, 0, 0, 0, 0, 0, 0);
        add_cfg(bsst_pkg::CFG_SLOTS_IN_USE, 16);
        add_item(bsst_pkg::FUNC_ACQUIRE, 15, 3, 0, 0, 0, 0, 0);
        add_item(bsst_pkg::FUNC_SET, 10, 10, 14, 3, 0, 0, 0);
        add_cfg(bsst_pkg::CFG_SLOTS_IN_USE, 1);
        add_item(bsst_pkg::FUNC_SET, 0, 2, 1, 0, 1, 0, 0);
        add_item(bsst_pkg::FUNC_ACQUIRE, 5, 7, 0, 0, 0, 0, 0);
        add_cfg(bsst_pkg::CFG_IDLE_CODE, 0);
        add_item(bsst_pkg::FUNC_SET, 0, 7, 0, 1, 0, 0, 0);

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (stim_tbl[k]) begin
            if (stim_tbl[k].kind == ROW_CFG) begin
                set_reg(stim_tbl[k].ridx, stim_tbl[k].rval);
            end else begin
                drive_word(stim_tbl[k].rq, stim_tbl[k].lit, stim_tbl[k].want);
            end
        end

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: u = 16;
                1: u = 13;
                2: u = 1;
                3: u = 31;
                4: u = 0;
                5: u = 8;
                6: u = 16;
                7: u = 3;
                8: u = $urandom_range(15, 2);
                default: u = $urandom_range(31, 17);
            endcase
            set_reg(bsst_pkg::CFG_SLOTS_IN_USE, bsst_pkg::CFG_W'(u));
            if (ph == 0) begin
                set_reg(bsst_pkg::CFG_IDLE_CODE, bsst_pkg::CFG_W'(0));
            end else if (ph == 1) begin
                set_reg(bsst_pkg::CFG_IDLE_CODE, bsst_pkg::CFG_W'(15));
            end else begin
                set_reg(bsst_pkg::CFG_IDLE_CODE, bsst_pkg::CFG_W'($urandom_range(15)));
            end
            idle_on = (ph != 6);
            nitems  = (u == 0) ? 40 : 205;
            for (int k = 0; k < nitems; k++) begin
                rq = gen_slot_op();
                drive_word(rq, 1'b0, nil);
            end
        end

        i_start <= 1'b0;
        while (rsp_pending.size() != 0) @(negedge i_clk);
        repeat (24) @(negedge i_clk);
        if (errs == 0 && rsp_pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
